>>> src/stx_pkg.sv
// Shared types, codes and constants of the source text tokenizer.
package stx_pkg;

	// Default width of the character position counter.
	localparam int POS_BITS_DEF = 16;

	// Width of reported offsets and lengths.
	localparam int OUT_BITS = 16;

	// Result queue depth and pointer width.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_BITS = $clog2(RQ_DEPTH);

	// Character codes with a special meaning.
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;

	// Token kinds as reported on the result side.
	typedef enum logic [2:0] {
		KIND_OPEN   = 3'd0,
		KIND_CLOSE  = 3'd1,
		KIND_QUOTE  = 3'd2,
		KIND_LABEL  = 3'd3,
		KIND_SYMBOL = 3'd4,
		KIND_END    = 3'd5
	} kind_t;

	// Scanner modes.
	typedef enum logic [1:0] {
		MODE_GAP   = 2'd0,
		MODE_LABEL = 2'd1,
		MODE_QUOTE = 2'd2
	} mode_t;

	// One result item.
	typedef struct packed {
		kind_t                 kind;
		logic [OUT_BITS-1:0]   offset;
		logic [OUT_BITS-1:0]   length;
		logic                  done;
		logic                  last;
	} res_t;

	// Results produced by one accepted request, first result in r0.
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} scan_out_t;

endpackage

>>> src/stx_scan.sv
// Scanner state and per-character token decode.
module stx_scan #(
	parameter int POS_BITS = stx_pkg::POS_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          char_code,
	input  logic                char_valid,
	input  logic                end_of_stream,
	output stx_pkg::scan_out_t  results
);
	import stx_pkg::*;

	typedef struct packed {
		logic                vld;
		kind_t               kind;
		logic [OUT_BITS-1:0] offset;
		logic [OUT_BITS-1:0] length;
	} tok_t;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	mode_t               mode_q, mode_d;
	logic                dquote_q, dquote_d;
	logic                esc_q, esc_d;
	logic [POS_BITS-1:0] begin_q, begin_d;
	logic [POS_BITS-1:0] pos_q, pos_d;

	tok_t                e1, e2, e3;
	logic                start_gap;
	logic [7:0]          quote_ch;
	logic [1:0]          count;

	// Saturate a position-derived value to the reported width.
	function automatic logic [OUT_BITS-1:0] clamp_out(input logic [32:0] v);
		logic [32:0] lim;
		lim = 33'(17'h0FFFF);
		clamp_out = (v > lim) ? '1 : v[OUT_BITS-1:0];
	endfunction

	function automatic logic [POS_BITS-1:0] span(input logic [POS_BITS-1:0] from,
		input logic [POS_BITS-1:0] upto);
		span = (upto >= from) ? upto - from : '0;
	endfunction

	function automatic logic is_gap(input logic [7:0] c);
		is_gap = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		is_word_char = (c == CH_UNDERSCORE) || (c inside {[8'h30:8'h39]}) ||
			(c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
	endfunction

	// Decode one request against the current mode.
	always_comb begin
		mode_d    = mode_q;
		dquote_d  = dquote_q;
		esc_d     = esc_q;
		begin_d   = begin_q;
		pos_d     = pos_q;
		e1        = '0;
		e2        = '0;
		e3        = '0;
		start_gap = 1'b0;
		quote_ch  = dquote_q ? CH_DQUOTE : CH_SQUOTE;

		if (accept && char_valid) begin
			case (mode_q)
				MODE_QUOTE: begin
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (char_code == CH_BACKSLASH) begin
						esc_d = 1'b1;
					end else if (char_code == quote_ch) begin
						e1.vld    = 1'b1;
						e1.kind   = KIND_QUOTE;
						e1.offset = clamp_out(33'(begin_q));
						e1.length = clamp_out(33'(span(begin_q, pos_q)) + 33'd1);
						mode_d    = MODE_GAP;
					end
				end
				MODE_LABEL: begin
					if (!is_word_char(char_code)) begin
						e1.vld    = 1'b1;
						e1.kind   = KIND_LABEL;
						e1.offset = clamp_out(33'(begin_q));
						e1.length = clamp_out(33'(span(begin_q, pos_q)));
						mode_d    = MODE_GAP;
						start_gap = 1'b1;
					end
				end
				default: begin
					mode_d    = MODE_GAP;
					start_gap = 1'b1;
				end
			endcase

			// Classify a character seen between tokens.
			if (start_gap && !is_gap(char_code)) begin
				e2.offset = clamp_out(33'(pos_q));
				e2.length = 16'd1;
				if (char_code inside {CH_LPAREN, CH_LBRACKET, CH_LBRACE}) begin
					e2.vld  = 1'b1;
					e2.kind = KIND_OPEN;
				end else if (char_code inside {CH_RPAREN, CH_RBRACKET, CH_RBRACE}) begin
					e2.vld  = 1'b1;
					e2.kind = KIND_CLOSE;
				end else if (char_code inside {CH_SQUOTE, CH_DQUOTE}) begin
					mode_d   = MODE_QUOTE;
					dquote_d = (char_code == CH_DQUOTE);
					esc_d    = 1'b0;
					begin_d  = pos_q;
				end else if (is_word_char(char_code)) begin
					mode_d  = MODE_LABEL;
					begin_d = pos_q;
				end else begin
					e2.vld  = 1'b1;
					e2.kind = KIND_SYMBOL;
				end
			end

			if (pos_q != POS_MAX) begin
				pos_d = pos_q + 1'b1;
			end
		end

		// Close the stream: flush an open label or, if no other token came, report the end marker.
		if (accept && end_of_stream) begin
			if (mode_d == MODE_LABEL) begin
				e3.vld    = 1'b1;
				e3.kind   = KIND_LABEL;
				e3.offset = clamp_out(33'(begin_d));
				e3.length = clamp_out(33'(span(begin_d, pos_d)));
			end else if (!e1.vld && !e2.vld) begin
				e3.vld    = 1'b1;
				e3.kind   = KIND_END;
				e3.offset = clamp_out(33'(pos_d));
				e3.length = '0;
			end
			mode_d   = MODE_GAP;
			dquote_d = 1'b0;
			esc_d    = 1'b0;
			begin_d  = '0;
			pos_d    = '0;
		end
	end

	// Order the up to two tokens of this request.
	always_comb begin
		tok_t t0, t1;
		count = 2'(e1.vld) + 2'(e2.vld) + 2'(e3.vld);
		if (e1.vld) begin
			t0 = e1;
			t1 = e2.vld ? e2 : e3;
		end else if (e2.vld) begin
			t0 = e2;
			t1 = e3;
		end else begin
			t0 = e3;
			t1 = '0;
		end
		results.count     = count;
		results.r0.kind   = t0.kind;
		results.r0.offset = t0.offset;
		results.r0.length = t0.length;
		results.r0.last   = (count == 2'd1);
		results.r0.done   = end_of_stream && (count == 2'd1);
		results.r1.kind   = t1.kind;
		results.r1.offset = t1.offset;
		results.r1.length = t1.length;
		results.r1.last   = 1'b1;
		results.r1.done   = end_of_stream;
	end

	// Scanner state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_GAP;
			dquote_q <= 1'b0;
			esc_q    <= 1'b0;
			begin_q  <= '0;
			pos_q    <= '0;
		end else begin
			mode_q   <= mode_d;
			dquote_q <= dquote_d;
			esc_q    <= esc_d;
			begin_q  <= begin_d;
			pos_q    <= pos_d;
		end
	end

endmodule

>>> src/stx_resq.sv
// Result queue: takes up to two results per cycle, hands out one while the reader is ready.
module stx_resq (
	input  logic               clk,
	input  logic               arst_n,
	input  stx_pkg::scan_out_t push,
	output logic               has_room,
	output logic               out_valid,
	input  logic               out_ready,
	output stx_pkg::res_t      out_res
);
	import stx_pkg::*;

	res_t                   mem_q [RQ_DEPTH];
	logic [RQ_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [RQ_PTR_BITS:0]   count_q;
	logic                   pop;

	// Room for the largest burst of one request.
	assign has_room  = (count_q <= (RQ_PTR_BITS+1)'(RQ_DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Result storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= push.r1;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_PTR_BITS'(push.count);
			rd_ptr_q <= rd_ptr_q + RQ_PTR_BITS'(pop);
			count_q  <= count_q + (RQ_PTR_BITS+1)'(push.count) - (RQ_PTR_BITS+1)'(pop);
		end
	end

endmodule

>>> src/source_text_tokenizer.sv
// Top level of the source text tokenizer: stream ports, scanner and result queue.
// A completing request writes its token into the result queue, which feeds the master side.
// Throughput: one character per cycle unless stalled; two tokens of a request leave one by one.
// The slave side stalls while the four-entry result queue has fewer than two free slots.
// Reset: arst_n asynchronously clears the scanner to between-tokens at offset zero and
// empties the result queue.
module source_text_tokenizer #(
	parameter int POS_BITS = stx_pkg::POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic [0:0]  s_tuser,  // [0] char_valid
	input  logic        s_tlast,  // end_of_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] token_offset, [31:16] token_length
	output logic [3:0]  m_tuser,  // [2:0] token_kind, [3] run_last
	output logic        m_tlast   // stream_done
);
	import stx_pkg::*;

	scan_out_t scan_res;
	res_t      head;
	logic      accept;

	assign accept = s_tvalid && s_tready;

	stx_scan #(
		.POS_BITS(POS_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.char_code     (s_tdata),
		.char_valid    (s_tuser[0]),
		.end_of_stream (s_tlast),
		.results       (scan_res)
	);

	stx_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (scan_res),
		.has_room  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (head)
	);

	// Pack the head result onto the master side.
	assign m_tdata = {head.length, head.offset};
	assign m_tuser = {head.last, head.kind};
	assign m_tlast = head.done;

endmodule
